FILE: design/nfcs_pkg.sv
// Shared types, constants and helpers for the nearest free cell search block.
// Used by nfcs_grid_ram, nfcs_ring_walk and the top level; depends on nothing.
`default_nettype none

package nfcs_pkg;

  // Grid geometry. Cell (x, y) lives at entry y * GridSide + x.
  localparam int GridSide  = 256;
  localparam int GridBits  = $clog2(GridSide);
  localparam int GridCells = GridSide * GridSide;
  localparam int AddrW     = 2 * GridBits;
  localparam int DimW      = GridBits + 1;

  // Ring search limits.
  localparam int MaxRadius = 64;
  localparam int RadW      = 7;
  localparam int RingW     = $clog2(MaxRadius);
  localparam int OffW      = RingW + 1;

  // Field widths.
  localparam int CoordW = 10;
  localparam int SumW   = ((CoordW > OffW) ? CoordW : OffW) + 1;
  localparam int CostW  = 8;
  localparam int OutXW  = 9;
  localparam int CfgIdxW = 1;

  localparam int SafeLimit = 50;

  // Command codes.
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegGridWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegGridHeight = 1'b1;

  // Result status codes.
  localparam logic [1:0] StatusSafe  = 2'd0;
  localparam logic [1:0] StatusFound = 2'd1;
  localparam logic [1:0] StatusNone  = 2'd2;

  // Candidate cell offered by the ring walker.
  typedef struct packed {
    logic                   active;
    logic                   on_grid;
    logic signed [SumW-1:0] x;
    logic signed [SumW-1:0] y;
  } walk_cand_t;

  function automatic logic on_grid(input logic signed [SumW-1:0] x,
                                   input logic signed [SumW-1:0] y,
                                   input logic [DimW-1:0]        w,
                                   input logic [DimW-1:0]        h);
    on_grid = !x[SumW-1] && !y[SumW-1] &&
              (x < {{(SumW-DimW){1'b0}}, w}) &&
              (y < {{(SumW-DimW){1'b0}}, h});
  endfunction

  function automatic logic [AddrW-1:0] cell_addr(input logic signed [SumW-1:0] x,
                                                 input logic signed [SumW-1:0] y);
    cell_addr = {y[GridBits-1:0], x[GridBits-1:0]};
  endfunction

endpackage

`default_nettype wire

FILE: design/nfcs_grid_ram.sv
// Cost grid storage: one write port and one registered read port.
// Depends on nfcs_pkg for the grid size and the cost width.
`default_nettype none

module nfcs_grid_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [nfcs_pkg::AddrW-1:0] waddr_i,
  input  logic [nfcs_pkg::CostW-1:0] wdata_i,
  input  logic [nfcs_pkg::AddrW-1:0] raddr_i,
  output logic [nfcs_pkg::CostW-1:0] rdata_o
);
  import nfcs_pkg::*;

  logic [CostW-1:0] mem [GridCells];
  logic [CostW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/nfcs_ring_walk.sv
// Ring walker: steps through the perimeter cells of square rings around a start cell.
// Depends on nfcs_pkg for widths, the candidate struct and the grid bounds check.
`default_nettype none

module nfcs_ring_walk (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              step_i,
  input  logic signed [nfcs_pkg::CoordW-1:0] x_i,
  input  logic signed [nfcs_pkg::CoordW-1:0] y_i,
  input  logic [nfcs_pkg::RadW-1:0]         radius_i,
  input  logic [nfcs_pkg::DimW-1:0]         width_i,
  input  logic [nfcs_pkg::DimW-1:0]         height_i,
  output nfcs_pkg::walk_cand_t              cand_o
);
  import nfcs_pkg::*;

  logic signed [CoordW-1:0] base_x_q, base_x_d;
  logic signed [CoordW-1:0] base_y_q, base_y_d;
  logic [RadW-1:0]          rlim_q, rlim_d;
  logic [RingW-1:0]         r_q, r_d;
  logic signed [OffW-1:0]   dx_q, dx_d;
  logic signed [OffW-1:0]   dy_q, dy_d;
  logic                     act_q, act_d;

  logic [RadW-1:0]        rlim_clamp;
  logic signed [OffW-1:0] r_s, nr_s, nxt_neg;
  logic [RingW-1:0]       r_inc;
  logic                   ring_more;
  logic                   edge_col;
  logic signed [SumW-1:0] cx, cy;

  always_comb begin
    rlim_clamp = (radius_i > RadW'(MaxRadius)) ? RadW'(MaxRadius) : radius_i;
    r_s        = $signed({1'b0, r_q});
    nr_s       = -r_s;
    r_inc      = r_q + RingW'(1);
    nxt_neg    = -$signed({1'b0, r_inc});
    ring_more  = (RadW'(r_q) + RadW'(1)) < rlim_q;
    edge_col   = (dx_q == nr_s) || (dx_q == r_s);

    base_x_d = base_x_q;
    base_y_d = base_y_q;
    rlim_d   = rlim_q;
    r_d      = r_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    act_d    = act_q;

    if (start_i) begin
      base_x_d = x_i;
      base_y_d = y_i;
      rlim_d   = rlim_clamp;
      r_d      = RingW'(1);
      dx_d     = -OffW'(1);
      dy_d     = -OffW'(1);
      act_d    = rlim_clamp > RadW'(1);
    end else if (step_i && act_q) begin
      if (edge_col) begin
        // Outer columns of the ring are walked top to bottom in full.
        if (dy_q != r_s) begin
          dy_d = dy_q + OffW'(1);
        end else if (dx_q != r_s) begin
          dx_d = dx_q + OffW'(1);
          dy_d = nr_s;
        end else if (ring_more) begin
          r_d  = r_inc;
          dx_d = nxt_neg;
          dy_d = nxt_neg;
        end else begin
          act_d = 1'b0;
        end
      end else begin
        // Inner columns only touch the top and bottom edge of the ring.
        if (dy_q == nr_s) begin
          dy_d = r_s;
        end else begin
          dx_d = dx_q + OffW'(1);
          dy_d = nr_s;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      base_x_q <= '0;
      base_y_q <= '0;
      rlim_q   <= '0;
      r_q      <= '0;
      dx_q     <= '0;
      dy_q     <= '0;
    end else begin
      act_q    <= act_d;
      base_x_q <= base_x_d;
      base_y_q <= base_y_d;
      rlim_q   <= rlim_d;
      r_q      <= r_d;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
    end
  end

  assign cx = {{(SumW-CoordW){base_x_q[CoordW-1]}}, base_x_q} +
              {{(SumW-OffW){dx_q[OffW-1]}}, dx_q};
  assign cy = {{(SumW-CoordW){base_y_q[CoordW-1]}}, base_y_q} +
              {{(SumW-OffW){dy_q[OffW-1]}}, dy_q};

  assign cand_o.active  = act_q;
  assign cand_o.on_grid = on_grid(cx, cy, width_i, height_i);
  assign cand_o.x       = cx;
  assign cand_o.y       = cy;

endmodule

`default_nettype wire

FILE: design/costmap_nearest_free_cell_search.sv
// Nearest free cell search over a 256 x 256 occupancy cost grid held in one RAM.
// Write item: taken back to back. Query: the start cell is read first; when
// it is unsafe, the perimeter cells are walked ring by ring and the compare drains;
// then the result is posted. The input stalls until the result register is loaded.
// One grid RAM read port sets the rate of one cell per cycle.
// Reset clears control and sets both dimensions to 256; grid contents stay undefined.
`default_nettype none

module costmap_nearest_free_cell_search (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               cmd_i,
  input  logic signed [nfcs_pkg::CoordW-1:0] cell_x_i,
  input  logic signed [nfcs_pkg::CoordW-1:0] cell_y_i,
  input  logic signed [nfcs_pkg::CostW-1:0]  cell_cost_i,
  input  logic [nfcs_pkg::RadW-1:0]          radius_cells_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic [nfcs_pkg::OutXW-1:0]         found_x_o,
  output logic [nfcs_pkg::OutXW-1:0]         found_y_o,
  input  logic                               cfg_we_i,
  input  logic [nfcs_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [nfcs_pkg::DimW-1:0]          cfg_wdata_i
);
  import nfcs_pkg::*;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StStart  = 4'b0010,
    StScan   = 4'b0100,
    StFinish = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [DimW-1:0] grid_w_q, grid_h_q;
  logic [DimW-1:0] w_eff, h_eff;

  logic                   in_acc, query_acc;
  logic signed [SumW-1:0] in_x, in_y;
  logic                   in_on_grid;
  logic                   grid_we;
  logic [AddrW-1:0]       raddr;
  logic [CostW-1:0]       rdata;

  walk_cand_t cand;
  logic       walk_step;

  logic                  start_on_q;
  logic [OutXW-1:0]      start_x_q, start_y_q;
  logic                  pipe_v_q, pipe_v_d;
  logic [OutXW-1:0]      pipe_x_q, pipe_y_q;
  logic                  hit, start_safe;

  logic [1:0]            res_status_q, res_status_d;
  logic [OutXW-1:0]      res_x_q, res_x_d, res_y_q, res_y_d;
  logic                  out_valid_q, out_valid_d;
  logic [1:0]            out_status_q;
  logic [OutXW-1:0]      out_x_q, out_y_q;
  logic                  out_load;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= DimW'(GridSide);
      grid_h_q <= DimW'(GridSide);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegGridWidth:  grid_w_q <= cfg_wdata_i;
        RegGridHeight: grid_h_q <= cfg_wdata_i;
        default:       grid_w_q <= grid_w_q;
      endcase
    end
  end

  assign w_eff = (grid_w_q > DimW'(GridSide)) ? DimW'(GridSide) : grid_w_q;
  assign h_eff = (grid_h_q > DimW'(GridSide)) ? DimW'(GridSide) : grid_h_q;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign query_acc  = in_acc && (cmd_i == CmdQuery);
  assign in_x       = {{(SumW-CoordW){cell_x_i[CoordW-1]}}, cell_x_i};
  assign in_y       = {{(SumW-CoordW){cell_y_i[CoordW-1]}}, cell_y_i};
  assign in_on_grid = on_grid(in_x, in_y, w_eff, h_eff);
  assign grid_we    = in_acc && (cmd_i == CmdWrite) && in_on_grid;

  // While idle the read port follows the input so that a query's start cell is
  // ready in the cycle after it is taken; during a scan it follows the walker.
  assign raddr = (state_q == StIdle) ? cell_addr(in_x, in_y) : cell_addr(cand.x, cand.y);

  nfcs_grid_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i (cell_addr(in_x, in_y)),
    .wdata_i (cell_cost_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign walk_step = (state_q == StScan);

  nfcs_ring_walk u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (query_acc),
    .step_i   (walk_step),
    .x_i      (cell_x_i),
    .y_i      (cell_y_i),
    .radius_i (radius_cells_i),
    .width_i  (w_eff),
    .height_i (h_eff),
    .cand_o   (cand)
  );

  assign start_safe = start_on_q && !rdata[CostW-1] && (rdata < CostW'(SafeLimit));
  assign hit        = pipe_v_q && (rdata == '0);
  assign out_load   = (state_q == StFinish) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    res_status_d = res_status_q;
    res_x_d      = res_x_q;
    res_y_d      = res_y_q;
    pipe_v_d     = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (query_acc) begin
          state_d = StStart;
        end
      end
      StStart: begin
        if (start_safe) begin
          res_status_d = StatusSafe;
          res_x_d      = start_x_q;
          res_y_d      = start_y_q;
          state_d      = StFinish;
        end else begin
          state_d = StScan;
        end
      end
      StScan: begin
        // The candidate read now is checked next cycle; a hit drops it.
        pipe_v_d = cand.active && cand.on_grid && !hit;
        if (hit) begin
          res_status_d = StatusFound;
          res_x_d      = pipe_x_q;
          res_y_d      = pipe_y_q;
          state_d      = StFinish;
        end else if (!cand.active && !pipe_v_q) begin
          res_status_d = StatusNone;
          res_x_d      = '0;
          res_y_d      = '0;
          state_d      = StFinish;
        end
      end
      StFinish: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pipe_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pipe_v_q    <= pipe_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      start_on_q <= in_on_grid;
      start_x_q  <= cell_x_i[OutXW-1:0];
      start_y_q  <= cell_y_i[OutXW-1:0];
    end
    pipe_x_q     <= cand.x[OutXW-1:0];
    pipe_y_q     <= cand.y[OutXW-1:0];
    res_status_q <= res_status_d;
    res_x_q      <= res_x_d;
    res_y_q      <= res_y_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_x_q      <= res_x_q;
      out_y_q      <= res_y_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign found_x_o   = out_x_q;
  assign found_y_o   = out_y_q;

  // A compare in flight only exists while the rings are being scanned.
  a_pipe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_v_q |-> (state_q == StScan))
    else $error("scan compare pending outside the scan state");

  // The grid is only written between queries.
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grid_we |-> (state_q == StIdle))
    else $error("grid write while a query is running");

  // A fresh result always comes out of the finish state.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StFinish))
    else $error("result posted without finishing a query");

  // Not-found results carry zero coordinates.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == StatusNone)) |-> ((found_x_o == '0) && (found_y_o == '0)))
    else $error("not-found result with non-zero coordinates");

endmodule

`default_nettype wire

FILE: tb/costmap_nearest_free_cell_search_tb.sv
// Self-checking testbench for costmap_nearest_free_cell_search: cell writes and ring searches.
// A scoreboard class predicts each query from its own copy of the grid; needs only nfcs_pkg.
`timescale 1ns / 100ps

module costmap_nearest_free_cell_search_tb;
  import nfcs_pkg::*;

  localparam int QuietLimit = 60000;

  typedef struct {
    logic                     cmd;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CostW-1:0]  cost;
    logic [RadW-1:0]          radius;
  } cell_item_t;

  typedef struct {
    logic [1:0]       status;
    logic [OutXW-1:0] fx;
    logic [OutXW-1:0] fy;
  } search_result_t;

  class search_scoreboard;
    logic signed [CostW-1:0] cost_map [GridCells];
    int unsigned             width_reg;
    int unsigned             height_reg;
    search_result_t          pending_answers [$];
    int                      errors;

    function new();
      width_reg  = 256;
      height_reg = 256;
      errors     = 0;
    endfunction

    function int eff_w();
      return (width_reg > GridSide) ? GridSide : width_reg;
    endfunction

    function int eff_h();
      return (height_reg > GridSide) ? GridSide : height_reg;
    endfunction

    function bit on_map(int x, int y);
      return x >= 0 && y >= 0 && x < eff_w() && y < eff_h();
    endfunction

    function void set_dim(logic [CfgIdxW-1:0] idx, int unsigned value);
      if (idx == RegGridWidth) width_reg = value & 9'h1FF;
      else width_reg = width_reg;
      if (idx == RegGridHeight) height_reg = value & 9'h1FF;
    endfunction

    function search_result_t nearest_free_cell(int x, int y, int radius);
      search_result_t res;
      int r, dx, dy, c;
      res.status = StatusNone;
      res.fx     = '0;
      res.fy     = '0;
      if (on_map(x, y)) begin
        c = cost_map[y * GridSide + x];
        if (c >= 0 && c < SafeLimit) begin
          res.status = StatusSafe;
          res.fx     = 9'(x);
          res.fy     = 9'(y);
          return res;
        end
      end
      if (radius > MaxRadius) radius = MaxRadius;
      for (r = 1; r < radius; r++) begin
        for (dx = -r; dx <= r; dx++) begin
          for (dy = -r; dy <= r; dy++) begin
            // Only the perimeter of the square ring is visited.
            if (dx != -r && dx != r && dy != -r && dy != r) continue;
            if (on_map(x + dx, y + dy) && cost_map[(y + dy) * GridSide + x + dx] == 0) begin
              res.status = StatusFound;
              res.fx     = 9'(x + dx);
              res.fy     = 9'(y + dy);
              return res;
            end
          end
        end
      end
      return res;
    endfunction

    function void note_item(cell_item_t it);
      int x, y;
      x = it.x;
      y = it.y;
      if (it.cmd == CmdWrite) begin
        if (on_map(x, y)) cost_map[y * GridSide + x] = it.cost;
      end else begin
        pending_answers.insert(pending_answers.size(),
                               nearest_free_cell(x, y, int'(it.radius)));
      end
    endfunction

    function void check_result(logic [1:0] st, logic [OutXW-1:0] fx, logic [OutXW-1:0] fy);
      search_result_t want;
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: result with no query waiting, expected none, actual status %0d x %0d y %0d",
                 $time, st, fx, fy);
        return;
      end
      want = pending_answers.pop_front();
      if (st !== want.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, st);
      end
      if (fx !== want.fx) begin
        errors++;
        $display("%0t: found_x mismatch, expected %0d, actual %0d", $time, want.fx, fx);
      end
      if (fy !== want.fy) begin
        errors++;
        $display("%0t: found_y mismatch, expected %0d, actual %0d", $time, want.fy, fy);
      end
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     cmd_i;
  logic signed [CoordW-1:0] cell_x_i;
  logic signed [CoordW-1:0] cell_y_i;
  logic signed [CostW-1:0]  cell_cost_i;
  logic [RadW-1:0]          radius_cells_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [1:0]               status_o;
  logic [OutXW-1:0]         found_x_o;
  logic [OutXW-1:0]         found_y_o;
  logic                     cfg_we_i;
  logic [CfgIdxW-1:0]       cfg_index_i;
  logic [DimW-1:0]          cfg_wdata_i;

  costmap_nearest_free_cell_search uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .cell_x_i       (cell_x_i),
    .cell_y_i       (cell_y_i),
    .cell_cost_i    (cell_cost_i),
    .radius_cells_i (radius_cells_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .found_x_o      (found_x_o),
    .found_y_o      (found_y_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  search_scoreboard sb = new();
  bit               written_map [GridCells];
  bit               send_pause_en = 1'b1;
  bit               recv_pause_en = 1'b1;
  int               hold_len = 0;
  int               items_sent = 0;
  int               quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Any accepted item or result resets the count.
  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int n;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      n = 0;
      if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        sb.check_result(status_o, found_x_o, found_y_o);
        n = recv_pause_en ? $urandom_range(0, 6) : 0;
      end
      if (hold_len > 0) begin
        n        = hold_len;
        hold_len = 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic int pick_cost();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) return 0;
    if (sel < 50) return $urandom_range(1, 49);
    if (sel < 70) return $urandom_range(50, 100);
    if (sel < 85) return -1;
    return int'($urandom_range(0, 255)) - 128;
  endfunction

  // Mostly near a hot corner of the grid, so that earlier writes get reused.
  function automatic int pick_coord(int span);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return int'($urandom_range(0, 1023)) - 512;
    if (sel < 65) return int'($urandom_range(0, ((span < 20) ? span : 20) + 3)) - 2;
    return int'($urandom_range(0, span + 3)) - 2;
  endfunction

  function automatic int pick_radius();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 88) return $urandom_range(0, 8);
    if (sel < 97) return $urandom_range(9, 31);
    return $urandom_range(32, 127);
  endfunction

  // The area a query may read, one cell of margin past its last ring.
  function automatic int count_missing(int x, int y, int radius);
    int half, cx, cy, n;
    half = (radius > MaxRadius) ? MaxRadius : radius;
    if (half < 1) half = 1;
    n = 0;
    for (cy = y - half; cy <= y + half; cy++)
      for (cx = x - half; cx <= x + half; cx++)
        if (sb.on_map(cx, cy) && !written_map[cy * GridSide + cx]) n++;
    return n;
  endfunction

  task automatic send_item(input cell_item_t it);
    int gap, x, y;
    gap = send_pause_en ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= it.cmd;
    cell_x_i       <= it.x;
    cell_y_i       <= it.y;
    cell_cost_i    <= it.cost;
    radius_cells_i <= it.radius;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_item(it);
    x = it.x;
    y = it.y;
    if (it.cmd == CmdWrite && sb.on_map(x, y)) written_map[y * GridSide + x] = 1'b1;
    items_sent++;
  endtask

  task automatic run_write(input int x, input int y, input int cost);
    cell_item_t it;
    it.cmd    = CmdWrite;
    it.x      = CoordW'(x);
    it.y      = CoordW'(y);
    it.cost   = CostW'(cost);
    it.radius = RadW'($urandom);
    send_item(it);
  endtask

  // Every cell the search may touch is written before the query goes out.
  task automatic run_query(input int x, input int y, input int radius);
    cell_item_t it;
    int half, cx, cy;
    half = (radius > MaxRadius) ? MaxRadius : radius;
    if (half < 1) half = 1;
    for (cy = y - half; cy <= y + half; cy++)
      for (cx = x - half; cx <= x + half; cx++)
        if (sb.on_map(cx, cy) && !written_map[cy * GridSide + cx])
          run_write(cx, cy, pick_cost());
    it.cmd    = CmdQuery;
    it.x      = CoordW'(x);
    it.y      = CoordW'(y);
    it.cost   = CostW'($urandom);
    it.radius = RadW'(radius);
    send_item(it);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_dims(input int w, input int h);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegGridWidth;
    cfg_wdata_i <= DimW'(w);
    @(posedge clk_i);
    cfg_index_i <= RegGridHeight;
    cfg_wdata_i <= DimW'(h);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_dim(RegGridWidth, w);
    sb.set_dim(RegGridHeight, h);
  endtask

  initial begin : stimulus
    int phase, k, sel, w, h, x, y, r;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    cmd_i          <= CmdWrite;
    cell_x_i       <= '0;
    cell_y_i       <= '0;
    cell_cost_i    <= '0;
    radius_cells_i <= '0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= RegGridWidth;
    cfg_wdata_i    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items on the full grid that reset leaves in place.
    run_write(0, 0, 0);
    run_query(0, 0, 0);
    run_write(255, 255, 49);
    run_query(255, 255, 1);
    run_write(10, 10, 50);
    run_query(10, 10, 2);
    run_write(20, 20, -1);
    run_query(20, 20, 3);
    run_write(30, 30, 100);
    run_query(30, 30, 4);
    run_write(40, 40, -128);
    run_write(41, 41, 127);
    run_query(40, 40, 2);
    run_query(41, 41, 2);
    run_write(-512, 511, 0);
    run_write(511, -512, 0);
    run_write(256, 5, 0);
    run_query(-1, 0, 2);
    run_query(256, 255, 2);
    run_query(511, 511, 0);
    run_query(5, 5, 1);
    run_query(-512, -512, 127);
    set_dims(3, 2);
    run_query(1, 1, 127);
    run_query(-20, 0, 64);
    set_dims(0, 5);
    run_write(0, 0, 0);
    run_query(0, 0, 5);
    set_dims(511, 300);
    run_query(255, 255, 2);

    phase = 0;
    while (items_sent < 1500) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        w = $urandom_range(1, 16);
        h = $urandom_range(1, 16);
      end else if (sel < 60) begin
        w = 256;
        h = $urandom_range(1, 8);
        if ($urandom_range(0, 1) == 1) begin
          w = h;
          h = 256;
        end
      end else if (sel < 72) begin
        w = $urandom_range(200, 511);
        h = $urandom_range(200, 511);
      end else if (sel < 78) begin
        w = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 9);
        h = (w == 0) ? $urandom_range(0, 20) : 0;
      end else begin
        w = $urandom_range(0, 511);
        h = $urandom_range(0, 511);
      end
      set_dims(w, h);
      send_pause_en = ($urandom_range(0, 3) != 0);
      recv_pause_en = ($urandom_range(0, 3) != 0);
      // Now and then the result side holds off while items keep coming.
      if (phase % 4 == 0) hold_len = 300;
      for (k = 0; k < 120 && items_sent < 1500; k++) begin
        x = pick_coord(sb.eff_w());
        y = pick_coord(sb.eff_h());
        if ($urandom_range(0, 99) < 40) begin
          run_write(x, y, pick_cost());
        end else begin
          r = pick_radius();
          while (r > 1 && count_missing(x, y, r) > 100) r = r / 2;
          run_query(x, y, r);
        end
      end
      phase++;
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
design/nfcs_pkg.sv
design/nfcs_grid_ram.sv
design/nfcs_ring_walk.sv
design/costmap_nearest_free_cell_search.sv
tb/costmap_nearest_free_cell_search_tb.sv
